FILE: rtl/qxm_pkg.sv
// types, constants and step functions shared by the x-frame motor mixer
`timescale 1ns / 1ps
package qxm_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int DIV_STEPS = FRAC_BITS;
  localparam int SQ_STEPS  = FRAC_BITS + 1;
  localparam int NMIX      = 4;
  localparam int NLANE     = NMIX + 1;
  localparam int THR_LANE  = NMIX;

  typedef logic signed [15:0] demand_t;
  typedef logic [14:0]        thrust_t;
  typedef logic [2:0]         cfg_idx_t;
  typedef logic [14:0]        cfg_data_t;
  typedef logic [1:0]         slot_t;
  typedef logic signed [16:0] mix_t;
  typedef logic signed [17:0] sum_t;
  typedef logic signed [18:0] wide_t;
  typedef logic [29:0]        sq_rem_t;

  localparam demand_t ONE_D = demand_t'(ONE);

  localparam cfg_idx_t CFG_TILT_MIN = 3'd0;
  localparam cfg_idx_t CFG_MAP_0    = 3'd1;
  localparam cfg_idx_t CFG_MAP_1    = 3'd2;
  localparam cfg_idx_t CFG_MAP_2    = 3'd3;
  localparam cfg_idx_t CFG_MAP_3    = 3'd4;

  typedef struct packed {
    logic [16:0]          rem;
    logic [16:0]          dvs;
    logic [FRAC_BITS-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic                      thr_byp;
    thrust_t                   thr_val;
    logic [NMIX-1:0]           mix_byp;
    logic [NMIX-1:0]           mix_neg;
    logic [NMIX-1:0][15:0]     mix_val;
    demand_t                   yaw;
  } side_t;

  function automatic demand_t clamp_unit(demand_t v);
    if (v > ONE_D) return ONE_D;
    if (v < -ONE_D) return -ONE_D;
    return v;
  endfunction

  function automatic lane_t div_step(lane_t l);
    lane_t       o;
    logic [16:0] rem2;
    o    = l;
    rem2 = {l.rem[15:0], 1'b0};
    if (rem2 >= l.dvs) begin
      o.rem = rem2 - l.dvs;
      o.quo = {l.quo[FRAC_BITS-2:0], 1'b1};
    end else begin
      o.rem = rem2;
      o.quo = {l.quo[FRAC_BITS-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

FILE: rtl/qxm_in_if.sv
// demand transaction channel
`timescale 1ns / 1ps
interface qxm_in_if;
  import qxm_pkg::*;
  logic    valid;
  logic    ready;
  demand_t pitch_demand;
  demand_t roll_demand;
  demand_t yaw_demand;
  thrust_t throttle_demand;
  demand_t vertical_component;
  modport source (output valid, pitch_demand, roll_demand, yaw_demand, throttle_demand,
                  vertical_component, input ready);
  modport sink (input valid, pitch_demand, roll_demand, yaw_demand, throttle_demand,
                vertical_component, output ready);
endinterface

FILE: rtl/qxm_out_if.sv
// motor thrust transaction channel
`timescale 1ns / 1ps
interface qxm_out_if;
  import qxm_pkg::*;
  logic    valid;
  logic    ready;
  thrust_t motor_out_0;
  thrust_t motor_out_1;
  thrust_t motor_out_2;
  thrust_t motor_out_3;
  modport source (output valid, motor_out_0, motor_out_1, motor_out_2, motor_out_3,
                  input ready);
  modport sink (input valid, motor_out_0, motor_out_1, motor_out_2, motor_out_3,
                output ready);
endinterface

FILE: rtl/quad_x_motor_mixer_core.sv
// x-frame quadcopter motor mixer top level, pipelined
//
//  channel  | dir | contents
//  in_ch    | in  | pitch, roll, yaw, throttle demands, vertical component
//  out_ch   | out | four motor thrusts by output slot
//  cfg_*    | in  | tilt compensation minimum and motor map writes
//
// one transaction accepted per cycle while the output is not stalled
// built from the 14 stage divider lanes and the 15 stage square root
// synchronous active-low reset clears valid bits and sets config registers to defaults
// a stalled output freezes the whole pipeline, nothing dropped or repeated
`timescale 1ns / 1ps
module quad_x_motor_mixer_core (
  input  logic                clk,
  input  logic                rst_n,
  qxm_in_if.sink              in_ch,
  qxm_out_if.source           out_ch,
  input  logic                cfg_we,
  input  qxm_pkg::cfg_idx_t   cfg_index,
  input  qxm_pkg::cfg_data_t  cfg_wdata
);
  import qxm_pkg::*;

  logic [14:0] tilt_min_r;
  slot_t       map_r [NMIX];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tilt_min_r <= 15'd8192;
      map_r[0]   <= 2'd0;
      map_r[1]   <= 2'd1;
      map_r[2]   <= 2'd2;
      map_r[3]   <= 2'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TILT_MIN: tilt_min_r <= cfg_wdata;
        CFG_MAP_0:    map_r[0] <= cfg_wdata[1:0];
        CFG_MAP_1:    map_r[1] <= cfg_wdata[1:0];
        CFG_MAP_2:    map_r[2] <= cfg_wdata[1:0];
        CFG_MAP_3:    map_r[3] <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  logic    adv;
  logic    out_valid_r;
  thrust_t motor_r [NMIX];

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // front end
  demand_t     p_c, r_c, y_c;
  mix_t        mix_c  [NMIX];
  logic [16:0] mabs_c [NMIX];
  logic [16:0] mx_c;
  logic        norm_c;
  logic        zpos_c;
  logic [14:0] d_c;
  logic        thr_div_c;
  side_t       side_c;
  lane_t       lane_c [NLANE];

  always_comb begin
    p_c = clamp_unit(in_ch.pitch_demand);
    r_c = clamp_unit(in_ch.roll_demand);
    y_c = clamp_unit(in_ch.yaw_demand);
    mix_c[0] = -mix_t'(p_c) - mix_t'(r_c);
    mix_c[1] = -mix_t'(p_c) + mix_t'(r_c);
    mix_c[2] = mix_t'(p_c) - mix_t'(r_c);
    mix_c[3] = mix_t'(p_c) + mix_t'(r_c);
    mx_c = '0;
    for (int i = 0; i < NMIX; i++) begin
      mabs_c[i] = mix_c[i][16] ? 17'(-mix_c[i]) : 17'(mix_c[i]);
      if (mabs_c[i] > mx_c) mx_c = mabs_c[i];
    end
    norm_c    = mx_c > 17'(ONE);
    zpos_c    = !in_ch.vertical_component[15] && (in_ch.vertical_component != '0);
    d_c       = (in_ch.vertical_component[14:0] > tilt_min_r) ?
                in_ch.vertical_component[14:0] : tilt_min_r;
    thr_div_c = zpos_c && (in_ch.throttle_demand < d_c);

    side_c.thr_byp = !thr_div_c;
    side_c.thr_val = zpos_c ? thrust_t'(ONE) : in_ch.throttle_demand;
    side_c.yaw     = y_c;
    for (int i = 0; i < NMIX; i++) begin
      side_c.mix_byp[i] = !norm_c || (mabs_c[i] == mx_c);
      side_c.mix_neg[i] = mix_c[i][16];
      if (!norm_c) side_c.mix_val[i] = mix_c[i][15:0];
      else         side_c.mix_val[i] = mix_c[i][16] ? -ONE_D : ONE_D;
      lane_c[i].rem = mabs_c[i];
      lane_c[i].dvs = mx_c;
      lane_c[i].quo = '0;
    end
    lane_c[THR_LANE].rem = 17'(in_ch.throttle_demand);
    lane_c[THR_LANE].dvs = 17'(d_c);
    lane_c[THR_LANE].quo = '0;
  end

  // divider pipeline
  logic  dv_vld_r  [DIV_STEPS+1];
  side_t dv_side_r [DIV_STEPS+1];
  lane_t dv_lane_r [DIV_STEPS+1][NLANE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_STEPS; k++) dv_vld_r[k] <= 1'b0;
    end else if (adv) begin
      dv_vld_r[0] <= in_ch.valid;
      for (int k = 1; k <= DIV_STEPS; k++) dv_vld_r[k] <= dv_vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_side_r[0] <= side_c;
      for (int j = 0; j < NLANE; j++) dv_lane_r[0][j] <= lane_c[j];
      for (int k = 1; k <= DIV_STEPS; k++) begin
        dv_side_r[k] <= dv_side_r[k-1];
        for (int j = 0; j < NLANE; j++) dv_lane_r[k][j] <= div_step(dv_lane_r[k-1][j]);
      end
    end
  end

  // quotient select
  thrust_t thr_f_c;
  demand_t mixf_c [NMIX];
  side_t   dv_end;

  always_comb begin
    dv_end  = dv_side_r[DIV_STEPS];
    thr_f_c = dv_end.thr_byp ? dv_end.thr_val : thrust_t'(dv_lane_r[DIV_STEPS][THR_LANE].quo);
    for (int i = 0; i < NMIX; i++) begin
      if (dv_end.mix_byp[i])      mixf_c[i] = demand_t'(dv_end.mix_val[i]);
      else if (dv_end.mix_neg[i]) mixf_c[i] = -demand_t'(dv_lane_r[DIV_STEPS][i].quo);
      else                        mixf_c[i] = demand_t'(dv_lane_r[DIV_STEPS][i].quo);
    end
  end

  // square root pipeline
  logic    sq_vld_r  [SQ_STEPS+1];
  sq_rem_t sq_rem_r  [SQ_STEPS+1];
  thrust_t sq_root_r [SQ_STEPS+1];
  demand_t sq_mix_r  [SQ_STEPS+1][NMIX];
  demand_t sq_yaw_r  [SQ_STEPS+1];
  sq_rem_t sq_rem_nxt  [SQ_STEPS+1];
  thrust_t sq_root_nxt [SQ_STEPS+1];

  always_comb begin
    sq_rem_nxt[0]  = sq_rem_t'(thr_f_c) << FRAC_BITS;
    sq_root_nxt[0] = '0;
    for (int k = 1; k <= SQ_STEPS; k++) begin
      logic [30:0] t;
      t = (31'(sq_root_r[k-1]) << (SQ_STEPS - k + 1)) + (31'(1) << (2 * (SQ_STEPS - k)));
      if (31'(sq_rem_r[k-1]) >= t) begin
        sq_rem_nxt[k]  = sq_rem_t'(31'(sq_rem_r[k-1]) - t);
        sq_root_nxt[k] = sq_root_r[k-1] | (thrust_t'(1) << (SQ_STEPS - k));
      end else begin
        sq_rem_nxt[k]  = sq_rem_r[k-1];
        sq_root_nxt[k] = sq_root_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= SQ_STEPS; k++) sq_vld_r[k] <= 1'b0;
    end else if (adv) begin
      sq_vld_r[0] <= dv_vld_r[DIV_STEPS];
      for (int k = 1; k <= SQ_STEPS; k++) sq_vld_r[k] <= sq_vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= SQ_STEPS; k++) begin
        sq_rem_r[k]  <= sq_rem_nxt[k];
        sq_root_r[k] <= sq_root_nxt[k];
      end
      sq_yaw_r[0] <= dv_end.yaw;
      for (int i = 0; i < NMIX; i++) sq_mix_r[0][i] <= mixf_c[i];
      for (int k = 1; k <= SQ_STEPS; k++) begin
        sq_yaw_r[k] <= sq_yaw_r[k-1];
        for (int i = 0; i < NMIX; i++) sq_mix_r[k][i] <= sq_mix_r[k-1][i];
      end
    end
  end

  // throttle add and overshoot
  sum_t    ms_c [NMIX];
  sum_t    mxm_c;
  sum_t    over_c;
  logic    sa_vld_r;
  sum_t    sa_ms_r [NMIX];
  sum_t    sa_over_r;
  demand_t sa_yaw_r;

  always_comb begin
    mxm_c = sum_t'(ONE);
    for (int i = 0; i < NMIX; i++) begin
      ms_c[i] = sum_t'(sq_mix_r[SQ_STEPS][i]) + sum_t'(sq_root_r[SQ_STEPS]);
      if (ms_c[i] > mxm_c) mxm_c = ms_c[i];
    end
    over_c = mxm_c - sum_t'(ONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_vld_r <= 1'b0;
    end else if (adv) begin
      sa_vld_r <= sq_vld_r[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NMIX; i++) sa_ms_r[i] <= ms_c[i];
      sa_over_r <= over_c;
      sa_yaw_r  <= sq_yaw_r[SQ_STEPS];
    end
  end

  // yaw headroom, clamp and motor map
  thrust_t val_c  [NMIX];
  thrust_t slot_c [NMIX];

  always_comb begin
    for (int i = 0; i < NMIX; i++) begin
      wide_t mm, t, lo, hi, v;
      mm = wide_t'(sa_ms_r[i]) - wide_t'(sa_over_r);
      t  = (i == 1 || i == 2) ? wide_t'(sa_yaw_r) : -wide_t'(sa_yaw_r);
      lo = -mm;
      hi = wide_t'(ONE) - mm;
      if (t < lo) t = lo;
      if (t > hi) t = hi;
      v = mm + t;
      if (v < 0)                 val_c[i] = '0;
      else if (v > wide_t'(ONE)) val_c[i] = thrust_t'(ONE);
      else                       val_c[i] = thrust_t'(v);
    end
    for (int i = 0; i < NMIX; i++) slot_c[i] = '0;
    for (int i = 0; i < NMIX; i++) slot_c[map_r[i]] = val_c[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sa_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NMIX; i++) motor_r[i] <= slot_c[i];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.motor_out_0 = motor_r[0];
  assign out_ch.motor_out_1 = motor_r[1];
  assign out_ch.motor_out_2 = motor_r[2];
  assign out_ch.motor_out_3 = motor_r[3];

`ifndef SYNTH
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (motor_r[0] <= thrust_t'(ONE)) && (motor_r[1] <= thrust_t'(ONE)) &&
                    (motor_r[2] <= thrust_t'(ONE)) && (motor_r[3] <= thrust_t'(ONE)))
    else $error("motor thrust above full scale");

  a_over_removed: assert property (@(posedge clk) disable iff (!rst_n)
    sa_vld_r |-> (sa_ms_r[0] - sa_over_r <= sum_t'(ONE)) &&
                 (sa_ms_r[1] - sa_over_r <= sum_t'(ONE)) &&
                 (sa_ms_r[2] - sa_over_r <= sum_t'(ONE)) &&
                 (sa_ms_r[3] - sa_over_r <= sum_t'(ONE)))
    else $error("overshoot not removed");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && sa_vld_r) |=> out_valid_r)
    else $error("transaction lost at output register");

  a_no_over_when_low: assert property (@(posedge clk) disable iff (!rst_n)
    sa_vld_r |-> sa_over_r >= 0)
    else $error("negative overshoot");
`endif

endmodule
